[src/rwc_pkg.sv]
// Package for the replay window check block: item types, verdict codes,
// register indexes and reset values. No dependencies.
package rwc_pkg;

  localparam int unsigned SEQ_W        = 32;
  localparam int unsigned SPAN_W       = 6;
  localparam int unsigned CFG_DATA_W   = 32;
  localparam int unsigned WINDOW_BITS_DEF = 32;

  localparam logic [SEQ_W-1:0]  SEQ_LIMIT_RST   = '1;
  localparam logic [SPAN_W-1:0] WINDOW_SPAN_RST = 6'd32;

  typedef enum logic [0:0] {
    CFG_SEQ_LIMIT   = 1'b0,
    CFG_WINDOW_SPAN = 1'b1
  } cfg_index_t;

  typedef enum logic [0:0] {
    KIND_CHECK    = 1'b0,
    KIND_ROLLBACK = 1'b1
  } kind_t;

  typedef enum logic [2:0] {
    VERDICT_OK      = 3'd0,
    VERDICT_WRAPPED = 3'd1,
    VERDICT_REPLAY  = 3'd2,
    VERDICT_OLD     = 3'd3,
    VERDICT_ROLLED  = 3'd4
  } verdict_t;

  typedef struct packed {
    kind_t            kind;
    logic [SEQ_W-1:0] incoming_seq;
  } in_item_t;

  typedef struct packed {
    logic     accepted;
    verdict_t verdict;
  } out_item_t;

  typedef struct packed {
    logic [SEQ_W-1:0] last_accepted;
    logic [SEQ_W-1:0] highest_seen;
    logic [SEQ_W-1:0] saved_last;
    logic             first_pending;
  } seq_state_t;

endpackage

[src/replay_window_check_core.sv]
// Top level of the replay window check: input register, window state,
// configuration registers and result register. Depends on rwc_pkg and
// rwc_window_unit.
//
// Usage: each item on the in_ channel is either a sequence check or a
// rollback after a failed decryption; each item yields exactly one result
// on the out_ channel (accepted flag and verdict code).
// An item is taken when in_valid is high and in_stall is low; a result is
// taken when out_valid is high and out_stall is low.
// An accepted item sits in the input register until it advances into the
// result register and raises out_valid. Throughput: one item per cycle while
// out_stall is low; the compare, shift and mask update are combinational.
// When the receiver stalls, the result register holds and one more item
// waits in the input register; in_stall rises only when both are full.
// seq_limit and window_span are written through cfg_we/cfg_index/cfg_wdata,
// by the user only while no item is in flight; the block does not enforce it.
// Reset (rst_n low, synchronous) empties both registers, clears the window
// and rollback copies, sets the first-number flag and loads the default
// seq_limit (all ones) and window_span (32).
module replay_window_check_core import rwc_pkg::*; #(
  parameter int unsigned WINDOW_BITS = WINDOW_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_item,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_item,
  input  logic                  cfg_we,
  input  cfg_index_t            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic                   s1_valid_r;
  in_item_t               s1_item_r;
  logic                   out_valid_r;
  out_item_t              out_item_r;
  seq_state_t             st_r;
  seq_state_t             st_nxt;
  logic [WINDOW_BITS-1:0] seen_mask_r;
  logic [WINDOW_BITS-1:0] seen_mask_nxt;
  logic [WINDOW_BITS-1:0] saved_mask_r;
  logic [WINDOW_BITS-1:0] saved_mask_nxt;
  logic [SEQ_W-1:0]       seq_limit_r;
  logic [SPAN_W-1:0]      window_span_r;
  out_item_t              result;
  logic                   advance;
  logic                   in_take;

  assign advance   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !advance;
  assign in_take   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  rwc_window_unit #(
    .WINDOW_BITS(WINDOW_BITS)
  ) u_window (
    .item          (s1_item_r),
    .st            (st_r),
    .seen_mask     (seen_mask_r),
    .saved_mask    (saved_mask_r),
    .seq_limit     (seq_limit_r),
    .window_span   (window_span_r),
    .st_nxt        (st_nxt),
    .seen_mask_nxt (seen_mask_nxt),
    .saved_mask_nxt(saved_mask_nxt),
    .result        (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_take) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r <= in_item;
    end
    if (advance) begin
      out_item_r <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.last_accepted <= '0;
      st_r.highest_seen  <= '0;
      st_r.saved_last    <= '0;
      st_r.first_pending <= 1'b1;
      seen_mask_r        <= '0;
      saved_mask_r       <= '0;
    end else if (advance) begin
      st_r         <= st_nxt;
      seen_mask_r  <= seen_mask_nxt;
      saved_mask_r <= saved_mask_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_limit_r   <= SEQ_LIMIT_RST;
      window_span_r <= WINDOW_SPAN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SEQ_LIMIT:   seq_limit_r   <= cfg_wdata[SEQ_W-1:0];
        CFG_WINDOW_SPAN: window_span_r <= cfg_wdata[SPAN_W-1:0];
        default: ;
      endcase
    end
  end

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r && out_stall))
    else $error("input stalled with a free slot");

  a_rollback_result: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && s1_item_r.kind == KIND_ROLLBACK) |=>
      (out_valid_r && out_item_r.accepted && out_item_r.verdict == VERDICT_ROLLED))
    else $error("rollback item did not report rolled back");

  a_first_flag_no_reraise: assert property (@(posedge clk) disable iff (!rst_n)
    !$rose(st_r.first_pending))
    else $error("first-number flag set again without reset");

  a_accepted_matches_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_item_r.accepted ==
      (out_item_r.verdict == VERDICT_OK || out_item_r.verdict == VERDICT_ROLLED)))
    else $error("accepted flag disagrees with verdict");

  a_wrapped_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && result.verdict == VERDICT_WRAPPED) |=>
      ($stable(st_r) && $stable(seen_mask_r) && $stable(saved_mask_r)))
    else $error("wrapped item changed window state");

endmodule

[src/rwc_window_unit.sv]
// Next-state and verdict logic for one item of the replay window check.
// Depends on rwc_pkg.
module rwc_window_unit import rwc_pkg::*; #(
  parameter int unsigned WINDOW_BITS = WINDOW_BITS_DEF
) (
  input  in_item_t               item,
  input  seq_state_t             st,
  input  logic [WINDOW_BITS-1:0] seen_mask,
  input  logic [WINDOW_BITS-1:0] saved_mask,
  input  logic [SEQ_W-1:0]       seq_limit,
  input  logic [SPAN_W-1:0]      window_span,
  output seq_state_t             st_nxt,
  output logic [WINDOW_BITS-1:0] seen_mask_nxt,
  output logic [WINDOW_BITS-1:0] saved_mask_nxt,
  output out_item_t              result
);

  localparam int unsigned IDX_W = (WINDOW_BITS > 1) ? $clog2(WINDOW_BITS) : 1;
  localparam logic [SEQ_W-1:0] WIN = SEQ_W'(WINDOW_BITS);

  logic [SEQ_W-1:0]       seq;
  logic [SEQ_W-1:0]       dist_up;
  logic [SEQ_W-1:0]       dist_dn;
  logic [SEQ_W:0]         span_sum;
  logic [WINDOW_BITS-1:0] old_bit;
  verdict_t               verdict;

  assign seq      = item.incoming_seq;
  assign dist_up  = seq - st.highest_seen;
  assign dist_dn  = st.highest_seen - seq;
  assign span_sum = {1'b0, seq} + {{(SEQ_W + 1 - SPAN_W){1'b0}}, window_span};
  assign old_bit  = {{(WINDOW_BITS-1){1'b0}}, 1'b1} << dist_dn[IDX_W-1:0];

  always_comb begin
    st_nxt         = st;
    seen_mask_nxt  = seen_mask;
    saved_mask_nxt = saved_mask;
    verdict        = VERDICT_OK;
    if (item.kind == KIND_ROLLBACK) begin
      verdict = VERDICT_ROLLED;
      if (saved_mask != '0) begin
        seen_mask_nxt  = saved_mask;
        saved_mask_nxt = '0;
      end
      if (st.saved_last != '0) begin
        st_nxt.last_accepted = st.saved_last;
        st_nxt.saved_last    = '0;
      end
    end else if (st.last_accepted >= seq_limit) begin
      verdict = VERDICT_WRAPPED;
    end else begin
      st_nxt.saved_last = st.last_accepted;
      saved_mask_nxt    = seen_mask;
      if (seq > st.highest_seen) begin
        if (dist_up >= WIN) begin
          seen_mask_nxt = '0;
        end else begin
          seen_mask_nxt = seen_mask << dist_up[IDX_W-1:0];
        end
        st_nxt.highest_seen = seq;
      end else if (seq == st.highest_seen) begin
        if (!st.first_pending) begin
          verdict = VERDICT_REPLAY;
        end else begin
          st_nxt.first_pending = 1'b0;
        end
      end else if (span_sum < {1'b0, st.highest_seen} || dist_dn >= WIN) begin
        verdict = VERDICT_OLD;
      end else if ((seen_mask & old_bit) != '0) begin
        verdict = VERDICT_REPLAY;
      end else begin
        seen_mask_nxt = seen_mask | old_bit;
      end
      if (verdict == VERDICT_OK) begin
        st_nxt.last_accepted = seq;
      end
    end
    result.verdict  = verdict;
    result.accepted = (verdict == VERDICT_OK) || (verdict == VERDICT_ROLLED);
  end

endmodule
